@@ src/console_line_edit_buffer_defines.svh @@
// assertion helpers used by the line buffer datapath
`ifndef CONSOLE_LINE_EDIT_BUFFER_DEFINES_SVH
`define CONSOLE_LINE_EDIT_BUFFER_DEFINES_SVH

`define CLEB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define CLEB_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/cleb_pkg.sv @@
package cleb_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_LF   = 8'h0A;
  localparam logic [7:0] KEY_DEL  = 8'h7F;
  localparam logic [7:0] KEY_KILL = 8'h15;
  localparam logic [7:0] KEY_BS   = 8'h08;
  localparam logic [7:0] KEY_EOF  = 8'h04;
  localparam logic [7:0] KEY_DUMP = 8'h10;
  localparam logic [7:0] KEY_NUL  = 8'h00;

  typedef enum logic [1:0] {
    RS_DATA  = 2'd0,
    RS_EMPTY = 2'd1,
    RS_EOF   = 2'd2
  } read_status_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_DUMP  = 3'd1,
    KIND_KILL  = 3'd2,
    KIND_ERASE = 3'd3,
    KIND_STORE = 3'd4
  } key_kind_t;

  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_LOAD       = 4'd1,
    OP_ZERO       = 4'd2,
    OP_DUMP       = 4'd3,
    OP_ERASE      = 4'd4,
    OP_STORE      = 4'd5,
    OP_EMPTY      = 4'd6,
    OP_RD_ISSUE   = 4'd7,
    OP_RD_FINISH  = 4'd8,
    OP_KILL_START = 4'd9,
    OP_KILL_STEP  = 4'd10,
    OP_EMIT       = 4'd11
  } dp_op_t;

  // packed so that {pad, res} gives the output word, echo_valid lowest
  typedef struct packed {
    read_status_t read_status;
    logic [7:0]   read_char;
    logic         dump_request;
    logic         line_ready;
    logic [7:0]   erase_count;
    logic [7:0]   echo_char;
    logic         echo_valid;
  } res_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic      in_is_read;
    key_kind_t kind;
    logic      edit_eq_commit;
    logic      read_eq_commit;
    logic      room;
    logic      rdata_is_lf;
    logic      probe_eq_commit;
    logic      out_free;
  } dp_stat_t;

endpackage

@@ src/console_line_edit_buffer.sv @@
// Canonical terminal line buffer: keys and reads come in one word at a time, each giving exactly
// one result word, and a finished result may wait at the output while the next word is taken.
// Items are worked one at a time over a line store with registered read data. A key word's
// result is formed in DECODE and registered in EMIT; a read that finds data adds a READ state
// for the store read; a kill-line steps back in KILL, one erased character per step, up to
// BUF_DEPTH - 1 characters. The input is ready again only after EMIT. While an older result
// still waits unaccepted at the output, the next result and the input stall until the
// receiver takes it.
module console_line_edit_buffer import cleb_pkg::*; #(
  parameter int BUF_DEPTH = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // key_code[7:0], first_of_read[8], zero pad
  input  logic [0:0]             s_tuser,  // command[0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // echo_valid[0], echo_char[8:1], erase_count[16:9],
                                           // line_ready[17], dump_request[18], read_char[26:19],
                                           // read_status[28:27], zero pad
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  cleb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cleb_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

@@ src/cleb_datapath.sv @@
`include "console_line_edit_buffer_defines.svh"

module cleb_datapath import cleb_pkg::*; #(
  parameter int BUF_DEPTH = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [0:0]             s_tuser,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  ctl_cmd_t               cmd,
  output dp_stat_t               stat
);

  localparam int SLOT_W = $clog2(BUF_DEPTH);
  localparam int IDX_W  = SLOT_W + 1;
  localparam logic [IDX_W-1:0] DEPTH_I  = IDX_W'(BUF_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(2 * BUF_DEPTH - 1);
  localparam logic [IDX_W:0]   IDX_MOD  = (IDX_W + 1)'(2 * BUF_DEPTH);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] s;
    s = (i >= DEPTH_I) ? i - DEPTH_I : i;
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_dist(input logic [IDX_W-1:0] hi,
                                                input logic [IDX_W-1:0] lo);
    logic [IDX_W:0] d;
    d = {1'b0, hi} - {1'b0, lo};
    if (hi < lo) begin
      d = d + IDX_MOD;
    end
    return d[IDX_W-1:0];
  endfunction

  logic [7:0] line_store [BUF_DEPTH];
  logic [7:0] rdata;

  logic [IDX_W-1:0] read_index, read_index_next;
  logic [IDX_W-1:0] commit_index, commit_index_next;
  logic [IDX_W-1:0] edit_index, edit_index_next;
  logic [IDX_W-1:0] probe, probe_next;
  res_t             res, res_next;

  logic       in_cmd;
  logic [7:0] in_key;
  logic       in_first;

  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;

  logic              mem_we;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_waddr;
  logic [SLOT_W-1:0] mem_raddr;
  logic [7:0]        store_char;
  logic [IDX_W-1:0]  dist_er;
  logic [IDX_W-1:0]  dist_cr;
  key_kind_t         kind;

  assign store_char = (in_key == KEY_CR) ? KEY_LF : in_key;
  assign dist_er    = idx_dist(edit_index, read_index);
  assign dist_cr    = idx_dist(commit_index, read_index);

  always_comb begin
    unique case (in_key) inside
      KEY_DUMP:        kind = KIND_DUMP;
      KEY_KILL:        kind = KIND_KILL;
      KEY_BS, KEY_DEL: kind = KIND_ERASE;
      KEY_NUL:         kind = KIND_NONE;
      default:         kind = KIND_STORE;
    endcase
  end

  always_comb begin
    stat.in_is_read      = in_cmd;
    stat.kind            = kind;
    stat.edit_eq_commit  = (edit_index == commit_index);
    stat.read_eq_commit  = (read_index == commit_index);
    stat.room            = (dist_er < DEPTH_I);
    stat.rdata_is_lf     = (rdata == KEY_LF);
    stat.probe_eq_commit = (probe == commit_index);
    stat.out_free        = !out_valid || m_tready;
  end

  always_comb begin
    read_index_next   = read_index;
    commit_index_next = commit_index;
    edit_index_next   = edit_index;
    probe_next        = probe;
    res_next          = res;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    mem_waddr         = slot_of(edit_index);
    mem_raddr         = slot_of(read_index);
    unique case (cmd.op)
      OP_ZERO: begin
        res_next = '0;
      end
      OP_DUMP: begin
        res_next = '0;
        res_next.dump_request = 1'b1;
      end
      OP_ERASE: begin
        edit_index_next = idx_dec(edit_index);
        res_next = '0;
        res_next.erase_count = 8'd1;
      end
      OP_STORE: begin
        mem_we = 1'b1;
        edit_index_next = idx_inc(edit_index);
        res_next = '0;
        res_next.echo_valid = 1'b1;
        res_next.echo_char = store_char;
        if (store_char == KEY_LF || store_char == KEY_EOF ||
            dist_er == DEPTH_I - 1'b1) begin
          commit_index_next = idx_inc(edit_index);
          res_next.line_ready = 1'b1;
        end
      end
      OP_EMPTY: begin
        res_next = '0;
        res_next.read_status = RS_EMPTY;
      end
      OP_RD_ISSUE: begin
        mem_re = 1'b1;
      end
      OP_RD_FINISH: begin
        res_next = '0;
        if (rdata == KEY_EOF) begin
          if (in_first) begin
            read_index_next = idx_inc(read_index);
          end
          res_next.read_status = RS_EOF;
        end else begin
          read_index_next = idx_inc(read_index);
          res_next.read_char = rdata;
        end
      end
      OP_KILL_START: begin
        probe_next = idx_dec(edit_index);
        mem_re = 1'b1;
        mem_raddr = slot_of(idx_dec(edit_index));
        res_next = '0;
      end
      OP_KILL_STEP: begin
        edit_index_next = probe;
        res_next.erase_count = (res.erase_count == 8'hFF) ? 8'hFF
                                                          : res.erase_count + 8'd1;
        probe_next = idx_dec(probe);
        mem_re = 1'b1;
        mem_raddr = slot_of(idx_dec(probe));
      end
      OP_NONE, OP_LOAD, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[mem_waddr] <= store_char;
    end
    if (mem_re) begin
      rdata <= line_store[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index   <= '0;
      commit_index <= '0;
      edit_index   <= '0;
      probe        <= '0;
      out_valid    <= 1'b0;
    end else begin
      read_index   <= read_index_next;
      commit_index <= commit_index_next;
      edit_index   <= edit_index_next;
      probe        <= probe_next;
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (cmd.op == OP_LOAD) begin
      in_cmd   <= s_tuser[0];
      in_key   <= s_tdata[7:0];
      in_first <= s_tdata[8];
    end
    if (cmd.op == OP_EMIT) begin
      out_data <= {(OUT_TDATA_W - $bits(res_t))'(0), res};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  `CLEB_ASSERT_ALWAYS(a_ring_bound, (dist_er <= DEPTH_I), "edit index ran past the ring")
  `CLEB_ASSERT_ALWAYS(a_commit_order, (dist_cr <= dist_er), "commit index beyond edit index")
  `CLEB_ASSERT_IMPLIES(a_store_room, (cmd.op == OP_STORE), stat.room, "store into full ring")
  `CLEB_ASSERT_IMPLIES(a_kill_step, (cmd.op == OP_KILL_STEP), !stat.edit_eq_commit, "kill past commit")

endmodule

@@ src/cleb_ctrl.sv @@
module cleb_ctrl import cleb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_READ   = 5'b00100,
    S_KILL   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_EMIT;
        if (stat.in_is_read) begin
          if (stat.read_eq_commit) begin
            cmd.op = OP_EMPTY;
          end else begin
            cmd.op = OP_RD_ISSUE;
            state_next = S_READ;
          end
        end else begin
          unique case (stat.kind)
            KIND_DUMP: cmd.op = OP_DUMP;
            KIND_KILL: begin
              if (stat.edit_eq_commit) begin
                cmd.op = OP_ZERO;
              end else begin
                cmd.op = OP_KILL_START;
                state_next = S_KILL;
              end
            end
            KIND_ERASE: cmd.op = stat.edit_eq_commit ? OP_ZERO : OP_ERASE;
            KIND_STORE: cmd.op = stat.room ? OP_STORE : OP_ZERO;
            KIND_NONE:  cmd.op = OP_ZERO;
            default:    cmd.op = OP_ZERO;
          endcase
        end
      end
      S_READ: begin
        cmd.op = OP_RD_FINISH;
        state_next = S_EMIT;
      end
      S_KILL: begin
        if (stat.rdata_is_lf) begin
          state_next = S_EMIT;
        end else begin
          cmd.op = OP_KILL_STEP;
          if (stat.probe_eq_commit) begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ tb/console_line_edit_buffer_tb.sv @@
module console_line_edit_buffer_tb import cleb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 128;
  localparam int ITEMS     = 1300;
  localparam int LIMIT     = 1500000;
  localparam int LONG_HOLD = 400;

  class line_buffer_tracker;
    logic [7:0] ring [DEPTH];
    logic [7:0] rd_idx;
    logic [7:0] cm_idx;
    logic [7:0] ed_idx;
    res_t       due_results [$];
    int         errors;
    int         n_echo;
    int         n_dump;
    int         n_kill;
    int         longest_kill;
    int         n_full;
    int         n_drop;
    int         n_eof;
    int         n_empty;

    function new();
      foreach (ring[i]) ring[i] = KEY_NUL;
      rd_idx = '0;
      cm_idx = '0;
      ed_idx = '0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // works out the result of one accepted word and advances the ring
    function void note_item(bit is_read, logic [7:0] key, bit first);
      res_t       r;
      logic [7:0] c;
      logic [7:0] prev;
      logic [7:0] span;
      int         n;
      r = '0;
      if (!is_read) begin
        if (key == KEY_DUMP) begin
          r.dump_request = 1'b1;
          n_dump++;
        end else if (key == KEY_KILL) begin
          n = 0;
          prev = ed_idx - 8'd1;
          while (ed_idx != cm_idx && ring[prev[6:0]] != KEY_LF) begin
            ed_idx = prev;
            prev = ed_idx - 8'd1;
            n++;
          end
          r.erase_count = (n > 255) ? 8'd255 : n[7:0];
          if (n > 0) n_kill++;
          if (n > longest_kill) longest_kill = n;
        end else if (key == KEY_BS || key == KEY_DEL) begin
          if (ed_idx != cm_idx) begin
            ed_idx = ed_idx - 8'd1;
            r.erase_count = 8'd1;
          end
        end else if (key != KEY_NUL) begin
          span = ed_idx - rd_idx;
          if (!span[7]) begin
            c = (key == KEY_CR) ? KEY_LF : key;
            ring[ed_idx[6:0]] = c;
            ed_idx = ed_idx + 8'd1;
            r.echo_valid = 1'b1;
            r.echo_char = c;
            n_echo++;
            span = ed_idx - rd_idx;
            if (c == KEY_LF || c == KEY_EOF || span == 8'(DEPTH)) begin
              cm_idx = ed_idx;
              r.line_ready = 1'b1;
              if (span == 8'(DEPTH)) n_full++;
            end
          end else begin
            n_drop++;
          end
        end
      end else begin
        if (rd_idx == cm_idx) begin
          r.read_status = RS_EMPTY;
          n_empty++;
        end else begin
          c = ring[rd_idx[6:0]];
          if (c == KEY_EOF) begin
            if (first) rd_idx = rd_idx + 8'd1;
            r.read_status = RS_EOF;
            n_eof++;
          end else begin
            rd_idx = rd_idx + 8'd1;
            r.read_char = c;
            r.read_status = RS_DATA;
          end
        end
      end
      due_results.push_back(r);
    endfunction

    function void cmp(string f, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, f, want, got);
      end
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] w);
      res_t want;
      res_t got;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: word %h arrived with nothing expected", $time, w);
        return;
      end
      want = due_results.pop_front();
      got = w[$bits(res_t)-1:0];
      cmp("echo_valid", want.echo_valid, got.echo_valid);
      cmp("echo_char", want.echo_char, got.echo_char);
      cmp("erase_count", want.erase_count, got.erase_count);
      cmp("line_ready", want.line_ready, got.line_ready);
      cmp("dump_request", want.dump_request, got.dump_request);
      cmp("read_char", want.read_char, got.read_char);
      cmp("read_status", want.read_status, got.read_status);
      cmp("pad", '0, 8'(w[OUT_TDATA_W-1:$bits(res_t)]));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  line_buffer_tracker sb = new();
  int  n_sent = 0;
  int  cycles = 0;
  int  stall_left = 0;
  int  n_holds = 0;
  int  n_drains = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;

  console_line_edit_buffer #(.BUF_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function logic [7:0] pick_char();
    logic [7:0] c;
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(8'h20, 8'h7E));
    c = 8'($urandom_range(1, 255));
    while (c == KEY_BS || c == KEY_DEL || c == KEY_KILL || c == KEY_DUMP ||
           c == KEY_CR || c == KEY_LF || c == KEY_EOF)
      c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  task automatic send(bit is_read, logic [7:0] key, bit first);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_TDATA_W-9){1'b0}}, first, key};
    s_tuser <= is_read;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(is_read, key, first);
    if (is_read || key != KEY_NUL) n_sent++;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic press(logic [7:0] key);
    send(1'b0, key, 1'($urandom_range(0, 1)));
  endtask

  task automatic fetch(bit first);
    send(1'b1, 8'($urandom_range(0, 255)), first);
  endtask

  task automatic fetch_call(int n);
    for (int i = 0; i < n; i++) fetch(i == 0 || $urandom_range(0, 9) == 0);
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    n_drains++;
  endtask

  task automatic type_line(int len);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) press(KEY_BS);
      else if (r < 9) press(KEY_DEL);
      else if (r < 11) press(KEY_KILL);
      else if (r < 13) press(KEY_DUMP);
      else if (r < 14) press(KEY_NUL);
      else press(pick_char());
    end
    r = $urandom_range(0, 99);
    if (r < 35) press(KEY_CR);
    else if (r < 60) press(KEY_LF);
    else if (r < 75) press(KEY_EOF);
    else if (r < 85) press(KEY_KILL);
  endtask

  task automatic fill_ring();
    int n;
    n = $urandom_range(125, 140);
    repeat (n) press(pick_char());
    fetch_call(140);
  endtask

  // receiver side: random back-pressure plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
        n_holds++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        if (!no_idle) stall_left = idle_len();
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("console_line_edit_buffer: mismatch");
    $finish;
  end

  initial begin
    int seq;
    int r;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty ring, edits with nothing typed, storing and reading lines, end of file
    fetch(1'b1);
    press(KEY_BS);
    press(KEY_DEL);
    press(KEY_KILL);
    press(KEY_NUL);
    press(KEY_DUMP);
    press(8'h61);
    press(8'hFF);
    press(8'h80);
    press(KEY_BS);
    press(8'h01);
    press(KEY_KILL);
    press(8'h78);
    press(KEY_CR);
    fetch(1'b1);
    fetch(1'b0);
    fetch(1'b0);
    press(KEY_EOF);
    press(8'h7A);
    press(KEY_EOF);
    fetch(1'b1);
    fetch(1'b1);
    fetch(1'b0);
    fetch(1'b1);
    fetch(1'b0);

    seq = 0;
    while (n_sent < ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (seq == 8) begin
        no_idle = 1'b1;
        hold_req = 1'b1;
        type_line(30);
        fetch_call(10);
      end else if (seq == 3 || $urandom_range(0, 199) == 0) begin
        fill_ring();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          type_line(($urandom_range(0, 15) == 0) ? $urandom_range(40, 127)
                                                 : $urandom_range(0, 20));
          if ($urandom_range(0, 3) != 0) fetch_call($urandom_range(1, 24));
        end else if (r < 78) begin
          fetch_call($urandom_range(1, 8));
        end else begin
          repeat ($urandom_range(1, 10))
            send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        end
      end
      if (seq == 12 || $urandom_range(0, 24) == 0) settle();
      seq++;
    end

    no_idle = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("sent %0d words in %0d cycles: %0d echoed, %0d dropped, %0d full-ring commits",
             n_sent, cycles, sb.n_echo, sb.n_drop, sb.n_full);
    $display("%0d dumps, %0d kills (longest %0d), %0d eof reads, %0d empty reads, %0d holds, %0d drains",
             sb.n_dump, sb.n_kill, sb.longest_kill, sb.n_eof, sb.n_empty, n_holds, n_drains);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("console_line_edit_buffer: match");
    end else begin
      $display("console_line_edit_buffer: mismatch");
    end
    $finish;
  end

endmodule
